// ===== hdl/asn1_validity_window_check_macros.svh =====
// Assertion macros for the validity window check.
// Included by the RTL files that carry concurrent checks; no dependencies.
`ifndef ASN1_VALIDITY_WINDOW_CHECK_MACROS_SVH
`define ASN1_VALIDITY_WINDOW_CHECK_MACROS_SVH
`ifndef SYNTHESIS
`define ASN1VW_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define ASN1VW_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASN1VW_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define ASN1VW_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hdl/asn1vw_pkg.sv =====
// Shared types, constants and the month offset table for the window check.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package asn1vw_pkg;
	localparam int NOW_W  = 40;
	localparam int SECS_W = 39;
	localparam int TOT_W  = 41;
	localparam int YEAR_W = 14;

	localparam logic [7:0] TAG_UTC     = 8'h17;
	localparam logic [7:0] TAG_GEN     = 8'h18;
	localparam logic [7:0] LEN_UTC_MIN = 8'd13;
	localparam logic [7:0] LEN_GEN_MIN = 8'd15;

	localparam logic [13:0] YEAR_OFFSET  = 14'd400;
	localparam logic [12:0] DIV400_MUL   = 13'd5243;
	localparam int          DIV400_SHIFT = 21;
	localparam logic [17:0] DAYS_PER_ERA = 18'd146097;
	localparam logic [23:0] EPOCH_BIAS   = 24'd865565;
	localparam logic [16:0] SECS_PER_DAY = 17'd86400;

	typedef struct packed {
		logic              ok;
		logic [YEAR_W-1:0] year;
		logic [3:0]        mon;
		logic [4:0]        day;
		logic [6:0]        hh;
		logic [6:0]        mm;
		logic [6:0]        ss;
	} fields_t;

	// Day of year at which a March-based month starts.
	function automatic logic [8:0] month_start(input logic [3:0] mp);
		logic [8:0] r;
		unique case (mp)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

// ===== hdl/asn1vw_if.sv =====
// Valid/ready channel interfaces for timestamp queries and window verdicts.
// Depends on asn1vw_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface asn1vw_query_if;
	logic                         valid;
	logic                         ready;
	logic [asn1vw_pkg::NOW_W-1:0] now_seconds;
	logic [7:0]                   begin_tag;
	logic [7:0]                   begin_length;
	logic [63:0]                  begin_bytes_head;
	logic [47:0]                  begin_bytes_tail;
	logic [7:0]                   end_tag;
	logic [7:0]                   end_length;
	logic [63:0]                  end_bytes_head;
	logic [47:0]                  end_bytes_tail;

	modport source (output valid, now_seconds, begin_tag, begin_length, begin_bytes_head,
		begin_bytes_tail, end_tag, end_length, end_bytes_head, end_bytes_tail, input ready);
	modport sink (input valid, now_seconds, begin_tag, begin_length, begin_bytes_head,
		begin_bytes_tail, end_tag, end_length, end_bytes_head, end_bytes_tail, output ready);
endinterface

interface asn1vw_verdict_if;
	logic                                valid;
	logic                                ready;
	logic                                in_window;
	logic signed [asn1vw_pkg::SECS_W-1:0] begin_seconds;
	logic signed [asn1vw_pkg::SECS_W-1:0] end_seconds;
	logic                                begin_malformed;
	logic                                end_malformed;

	modport source (output valid, in_window, begin_seconds, end_seconds, begin_malformed,
		end_malformed, input ready);
	modport sink (input valid, in_window, begin_seconds, end_seconds, begin_malformed,
		end_malformed, output ready);
endinterface
`default_nettype wire

// ===== hdl/asn1_validity_window_check.sv =====
// Top level: two time conversion pipelines, window compare and output register.
// Depends on asn1vw_pkg, asn1vw_if, asn1vw_time_pipe and the assertion macros.
//
// channel  dir  handshake     payload
// query    in   valid/ready   now_seconds, begin_*/end_* tag, length, bytes
// verdict  out  valid/ready   in_window, begin/end_seconds, begin/end_malformed
//
// One item per cycle when not stalled; stages decode, era, era offset, day count,
// seconds, compare. The whole pipeline advances when the output register is empty
// or taken, so a stall freezes every stage. Reset clears the stage valid bits only.
`timescale 1ns / 1ps
`default_nettype none
`include "asn1_validity_window_check_macros.svh"
module asn1_validity_window_check (
	input  logic             clk,
	input  logic             arst_n,
	asn1vw_query_if.sink     query,
	asn1vw_verdict_if.source verdict
);
	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	assign adv         = !v_s6 || verdict.ready;
	assign query.ready = adv;

	logic signed [asn1vw_pkg::TOT_W-1:0] btot_s5, etot_s5;
	logic                                bok_s5, eok_s5;
	logic [asn1vw_pkg::NOW_W-1:0]        now_s1, now_s2, now_s3, now_s4, now_s5;

	asn1vw_time_pipe u_begin (
		.clk       (clk),
		.adv       (adv),
		.tag       (query.begin_tag),
		.length    (query.begin_length),
		.bytes_head(query.begin_bytes_head),
		.bytes_tail(query.begin_bytes_tail),
		.total_s5  (btot_s5),
		.ok_s5     (bok_s5)
	);

	asn1vw_time_pipe u_end (
		.clk       (clk),
		.adv       (adv),
		.tag       (query.end_tag),
		.length    (query.end_length),
		.bytes_head(query.end_bytes_head),
		.bytes_tail(query.end_bytes_tail),
		.total_s5  (etot_s5),
		.ok_s5     (eok_s5)
	);

	logic bbad, ebad, ge, le, inw;
	logic [asn1vw_pkg::TOT_W-1:0] now_ext;

	always_comb begin
		now_ext = asn1vw_pkg::TOT_W'(now_s5);
		bbad    = !bok_s5 || (btot_s5 == '0);
		ebad    = !eok_s5 || (etot_s5 == '0);
		// negative times compare as huge unsigned values
		ge      = !btot_s5[asn1vw_pkg::TOT_W-1] && (now_ext >= $unsigned(btot_s5));
		le      = etot_s5[asn1vw_pkg::TOT_W-1] || (now_ext <= $unsigned(etot_s5));
		inw     = !bbad && !ebad && ge && le;
	end

	logic                                 inw_s6, bbad_s6, ebad_s6;
	logic signed [asn1vw_pkg::SECS_W-1:0] bsec_s6, esec_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= query.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			now_s1  <= query.now_seconds;
			now_s2  <= now_s1;
			now_s3  <= now_s2;
			now_s4  <= now_s3;
			now_s5  <= now_s4;
			inw_s6  <= inw;
			bbad_s6 <= bbad;
			ebad_s6 <= ebad;
			bsec_s6 <= bbad ? '0 : btot_s5[asn1vw_pkg::SECS_W-1:0];
			esec_s6 <= ebad ? '0 : etot_s5[asn1vw_pkg::SECS_W-1:0];
		end
	end

	assign verdict.valid           = v_s6;
	assign verdict.in_window       = inw_s6;
	assign verdict.begin_seconds   = bsec_s6;
	assign verdict.end_seconds     = esec_s6;
	assign verdict.begin_malformed = bbad_s6;
	assign verdict.end_malformed   = ebad_s6;

	`ASN1VW_ASSERT_IMP(a_win_wellformed, clk, arst_n, verdict.valid && verdict.in_window, !verdict.begin_malformed && !verdict.end_malformed, "window set with malformed time")
	`ASN1VW_ASSERT_IMP(a_win_begin_pos, clk, arst_n, verdict.valid && verdict.in_window, !verdict.begin_seconds[asn1vw_pkg::SECS_W-1], "window set with negative begin")
	`ASN1VW_ASSERT_IMP(a_bad_zero, clk, arst_n, verdict.valid && verdict.begin_malformed, verdict.begin_seconds == '0, "malformed begin carries seconds")
	`ASN1VW_ASSERT_NXT(a_accept_enters, clk, arst_n, query.valid && query.ready, v_s1, "accepted item lost at entry")
endmodule
`default_nettype wire

// ===== hdl/asn1vw_field_decode.sv =====
// Splits one ASN.1 time body into binary date and clock fields and checks format.
// Depends on asn1vw_pkg.
`timescale 1ns / 1ps
`default_nettype none
module asn1vw_field_decode (
	input  logic [7:0]          tag,
	input  logic [7:0]          length,
	input  logic [63:0]         bytes_head,
	input  logic [47:0]         bytes_tail,
	output asn1vw_pkg::fields_t fields
);
	logic [7:0]  b   [14];
	logic [3:0]  dv  [14];
	logic [13:0] isdig;
	logic [7:0]  pv  [13];

	genvar i;
	generate
		for (i = 0; i < 14; i++) begin : g_byte
			if (i < 8) begin : g_head
				assign b[i] = bytes_head[63-8*i -: 8];
			end else begin : g_tail
				assign b[i] = bytes_tail[47-8*(i-8) -: 8];
			end
			assign dv[i]    = b[i][3:0];
			assign isdig[i] = (b[i] >= 8'h30) && (b[i] <= 8'h39);
		end
		for (i = 0; i < 13; i++) begin : g_pair
			assign pv[i] = 8'(dv[i]) * 8'd10 + 8'(dv[i+1]);
		end
	endgenerate

	logic       utc, gen, dig_ok;
	logic [7:0] mon, day, hh, mm, ss;

	always_comb begin
		utc    = (tag == asn1vw_pkg::TAG_UTC) && (length >= asn1vw_pkg::LEN_UTC_MIN);
		gen    = (tag == asn1vw_pkg::TAG_GEN) && (length >= asn1vw_pkg::LEN_GEN_MIN);
		dig_ok = gen ? (&isdig) : (&isdig[11:0]);
		mon    = gen ? pv[4]  : pv[2];
		day    = gen ? pv[6]  : pv[4];
		hh     = gen ? pv[8]  : pv[6];
		mm     = gen ? pv[10] : pv[8];
		ss     = gen ? pv[12] : pv[10];
		if (gen)
			fields.year = 14'(pv[0]) * 14'd100 + 14'(pv[2]);
		else if (pv[0] < 8'd50)
			fields.year = 14'd2000 + 14'(pv[0]);
		else
			fields.year = 14'd1900 + 14'(pv[0]);
		fields.ok  = (utc || gen) && dig_ok && (mon >= 8'd1) && (mon <= 8'd12)
			&& (day >= 8'd1) && (day <= 8'd31);
		fields.mon = mon[3:0];
		fields.day = day[4:0];
		fields.hh  = hh[6:0];
		fields.mm  = mm[6:0];
		fields.ss  = ss[6:0];
	end
endmodule
`default_nettype wire

// ===== hdl/asn1vw_time_pipe.sv =====
// Five-stage conversion of one ASN.1 time to signed Unix seconds (civil days method).
// Depends on asn1vw_pkg and asn1vw_field_decode.
`timescale 1ns / 1ps
`default_nettype none
module asn1vw_time_pipe (
	input  logic                                clk,
	input  logic                                adv,
	input  logic [7:0]                          tag,
	input  logic [7:0]                          length,
	input  logic [63:0]                         bytes_head,
	input  logic [47:0]                         bytes_tail,
	output logic signed [asn1vw_pkg::TOT_W-1:0] total_s5,
	output logic                                ok_s5
);
	asn1vw_pkg::fields_t fd, f_s1;

	asn1vw_field_decode u_dec (
		.tag       (tag),
		.length    (length),
		.bytes_head(bytes_head),
		.bytes_tail(bytes_tail),
		.fields    (fd)
	);

	// stage 2: shifted year, era by reciprocal, day of year, clock seconds
	logic [3:0]  mp;
	logic [13:0] yadj;
	logic [26:0] qprod;
	logic [18:0] hms;
	logic [8:0]  doy;
	logic [13:0] yadj_s2;
	logic [4:0]  q_s2;
	logic [18:0] hms_s2, hms_s3, hms_s4;
	logic [8:0]  doy_s2, doy_s3;
	logic        ok_s2, ok_s3, ok_s4;

	always_comb begin
		mp    = (f_s1.mon > 4'd2) ? f_s1.mon - 4'd3 : f_s1.mon + 4'd9;
		yadj  = f_s1.year + asn1vw_pkg::YEAR_OFFSET - 14'(f_s1.mon <= 4'd2);
		qprod = 27'(yadj) * 27'(asn1vw_pkg::DIV400_MUL);
		hms   = 19'(f_s1.hh) * 19'd3600 + 19'(f_s1.mm) * 19'd60 + 19'(f_s1.ss);
		doy   = asn1vw_pkg::month_start(mp) + 9'(f_s1.day) - 9'd1;
	end

	// stage 3: year of era, era day offset
	logic [8:0]  yoe, yoe_s3;
	logic [21:0] qmul_s3;

	assign yoe = 9'(yadj_s2 - 14'(q_s2) * 14'd400);

	// stage 4: day of era and day count from the epoch
	logic [1:0]         hund;
	logic [17:0]        doe;
	logic signed [23:0] days, days_s4;

	always_comb begin
		if (yoe_s3 >= 9'd300)      hund = 2'd3;
		else if (yoe_s3 >= 9'd200) hund = 2'd2;
		else if (yoe_s3 >= 9'd100) hund = 2'd1;
		else                       hund = 2'd0;
		doe  = 18'(yoe_s3) * 18'd365 + 18'(yoe_s3[8:2]) - 18'(hund) + 18'(doy_s3);
		days = $signed(24'(qmul_s3) + 24'(doe) - asn1vw_pkg::EPOCH_BIAS);
	end

	// stage 5: seconds
	logic signed [asn1vw_pkg::TOT_W-1:0] tot;

	assign tot = asn1vw_pkg::TOT_W'(days_s4)
		* $signed(asn1vw_pkg::TOT_W'(asn1vw_pkg::SECS_PER_DAY))
		+ $signed(asn1vw_pkg::TOT_W'(hms_s4));

	always_ff @(posedge clk) begin
		if (adv) begin
			f_s1     <= fd;
			yadj_s2  <= yadj;
			q_s2     <= qprod[asn1vw_pkg::DIV400_SHIFT +: 5];
			hms_s2   <= hms;
			doy_s2   <= doy;
			ok_s2    <= f_s1.ok;
			yoe_s3   <= yoe;
			qmul_s3  <= 22'(q_s2) * 22'(asn1vw_pkg::DAYS_PER_ERA);
			hms_s3   <= hms_s2;
			doy_s3   <= doy_s2;
			ok_s3    <= ok_s2;
			days_s4  <= days;
			hms_s4   <= hms_s3;
			ok_s4    <= ok_s3;
			total_s5 <= tot;
			ok_s5    <= ok_s4;
		end
	end
endmodule
`default_nettype wire
